### src/lcd_seq_pkg.sv
// Package: request kinds, register indexes and the sequencer microcode table.
package lcd_seq_pkg;

    localparam int GLYPH_ROW_COUNT = 8;
    localparam int ROW_CNT_W       = $clog2(GLYPH_ROW_COUNT);
    localparam int PC_W            = 5;
    localparam int WAIT_W          = 16;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_GOTO  = 2'd1;
    localparam logic [1:0] KIND_GLYPH = 2'd2;
    localparam logic [1:0] KIND_INIT  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_CURSOR_BLINK = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NIBBLE_WAIT  = 1'd1;

    localparam logic [WAIT_W-1:0] NIBBLE_WAIT_RESET = 16'd110;

    // entry points of the microprogram
    localparam logic [PC_W-1:0] PC_BYTE    = 5'd0;
    localparam logic [PC_W-1:0] PC_GOTO    = 5'd2;
    localparam logic [PC_W-1:0] PC_GLYPH   = 5'd4;
    localparam logic [PC_W-1:0] PC_ROW_TOP = 5'd6;
    localparam logic [PC_W-1:0] PC_INIT    = 5'd8;

    typedef enum logic [3:0] {
        NS_CONST,
        NS_BYTE_HI,
        NS_BYTE_LO,
        NS_GOTO_HI,
        NS_GOTO_LO,
        NS_CG_HI,
        NS_CG_LO,
        NS_ROW_HI,
        NS_ROW_LO,
        NS_BLINK_LO
    } t_nib_src;

    typedef enum logic [1:0] {
        SS_ZERO,
        SS_ONE,
        SS_IS_DATA
    } t_sel_src;

    typedef enum logic [2:0] {
        EX_NONE,
        EX_POWER_UP,
        EX_FUNC_SET,
        EX_SHORT,
        EX_ENTRY_MODE
    } t_extra;

    typedef enum logic [1:0] {
        FL_NEXT,
        FL_END,
        FL_ROW_LOOP
    } t_flow;

    typedef struct packed {
        t_nib_src   nib_src;
        logic [3:0] nib_const;
        t_sel_src   sel_src;
        t_extra     extra;
        t_flow      flow;
    } t_ctrl_word;

    function automatic t_ctrl_word ucode(input logic [PC_W-1:0] pc);
        t_ctrl_word w;
        w = '{nib_src: NS_CONST, nib_const: 4'h0, sel_src: SS_ZERO,
              extra: EX_NONE, flow: FL_END};
        case (pc)
            5'd0:  w = '{NS_BYTE_HI, 4'h0, SS_IS_DATA, EX_NONE, FL_NEXT};
            5'd1:  w = '{NS_BYTE_LO, 4'h0, SS_IS_DATA, EX_NONE, FL_END};
            5'd2:  w = '{NS_GOTO_HI, 4'h0, SS_ZERO, EX_NONE, FL_NEXT};
            5'd3:  w = '{NS_GOTO_LO, 4'h0, SS_ZERO, EX_NONE, FL_END};
            5'd4:  w = '{NS_CG_HI,   4'h0, SS_ZERO, EX_NONE, FL_NEXT};
            5'd5:  w = '{NS_CG_LO,   4'h0, SS_ZERO, EX_NONE, FL_NEXT};
            5'd6:  w = '{NS_ROW_HI,  4'h0, SS_ONE,  EX_NONE, FL_NEXT};
            5'd7:  w = '{NS_ROW_LO,  4'h0, SS_ONE,  EX_NONE, FL_ROW_LOOP};
            5'd8:  w = '{NS_CONST, 4'h3, SS_ZERO, EX_POWER_UP, FL_NEXT};
            5'd9:  w = '{NS_CONST, 4'h3, SS_ZERO, EX_FUNC_SET, FL_NEXT};
            5'd10: w = '{NS_CONST, 4'h3, SS_ZERO, EX_FUNC_SET, FL_NEXT};
            5'd11: w = '{NS_CONST, 4'h2, SS_ZERO, EX_SHORT, FL_NEXT};
            5'd12: w = '{NS_CONST, 4'h2, SS_ZERO, EX_NONE, FL_NEXT};
            5'd13: w = '{NS_CONST, 4'h8, SS_ZERO, EX_NONE, FL_NEXT};
            5'd14: w = '{NS_CONST, 4'h0, SS_ZERO, EX_NONE, FL_NEXT};
            5'd15: w = '{NS_BLINK_LO, 4'h0, SS_ZERO, EX_NONE, FL_NEXT};
            5'd16: w = '{NS_CONST, 4'h0, SS_ZERO, EX_NONE, FL_NEXT};
            5'd17: w = '{NS_CONST, 4'h1, SS_ZERO, EX_NONE, FL_NEXT};
            5'd18: w = '{NS_CONST, 4'h1, SS_ZERO, EX_ENTRY_MODE, FL_NEXT};
            5'd19: w = '{NS_CONST, 4'h6, SS_ZERO, EX_NONE, FL_NEXT};
            5'd20: w = '{NS_CONST, 4'h0, SS_ZERO, EX_NONE, FL_NEXT};
            5'd21: w = '{NS_CONST, 4'h2, SS_ZERO, EX_NONE, FL_END};
            default: w = '{NS_CONST, 4'h0, SS_ZERO, EX_NONE, FL_END};
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(input logic [1:0] kind);
        logic [PC_W-1:0] pc;
        case (kind)
            KIND_BYTE:  pc = PC_BYTE;
            KIND_GOTO:  pc = PC_GOTO;
            KIND_GLYPH: pc = PC_GLYPH;
            default:    pc = PC_INIT;
        endcase
        return pc;
    endfunction

    function automatic logic [WAIT_W-1:0] extra_wait(input t_extra ex);
        logic [WAIT_W-1:0] v;
        case (ex)
            EX_POWER_UP:   v = 16'd15000;
            EX_FUNC_SET:   v = 16'd42000;
            EX_SHORT:      v = 16'd110;
            EX_ENTRY_MODE: v = 16'd5000;
            default:       v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

### src/char_lcd_nibble_sequencer.sv
// Character LCD 4-bit bus sequencer: microcoded request-to-nibble converter.
// An accepted request loads the step counter; the first step then loads the nibble output register.
// Throughput: one nibble per cycle from a single microcode step counter without output stalls;
// a request emits N nibbles (N = 2 byte/cursor, 18 glyph, 14 init) and blocks new requests until its last.
// Reset: synchronous active-low; clears busy/valid, cursor_blink to 0, nibble_wait to 110.
// The microprogram ROM and the glyph row counter set the per-request nibble count.
module char_lcd_nibble_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [lcd_seq_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] byte_value, [13:8] column, [14] row, [17:15] glyph_code,
    // [81:18] glyph_rows, [87:82] zero
    input  logic [87:0] s_axis_tdata,
    // [1:0] kind, [2] is_data
    input  logic [2:0]  s_axis_tuser,
    // nibble stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] nibble, [19:4] wait_cycles, [23:20] zero
    output logic [23:0] m_axis_tdata,
    // [0] select_data
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int RW = lcd_seq_pkg::ROW_CNT_W;
    localparam int WW = lcd_seq_pkg::WAIT_W;

    // configuration registers
    logic          r_cursor_blink;
    logic [WW-1:0] r_nibble_wait;

    // captured request
    logic [7:0]  r_byte;
    logic        r_is_data;
    logic [5:0]  r_column;
    logic        r_row;
    logic [2:0]  r_glyph_code;
    logic [63:0] r_rows, n_rows;

    // sequencer control
    logic                       r_busy, n_busy;
    logic [lcd_seq_pkg::PC_W-1:0] r_pc, n_pc;
    logic [RW-1:0]              r_row_cnt, n_row_cnt;

    // output register
    logic          r_out_valid, n_out_valid;
    logic          r_out_sel, n_out_sel;
    logic [3:0]    r_out_nib, n_out_nib;
    logic [WW-1:0] r_out_wait, n_out_wait;
    logic          r_out_last, n_out_last;

    logic                   s_acc;
    logic                   step_en;
    lcd_seq_pkg::t_ctrl_word cw;
    logic [7:0]             goto_cmd;
    logic [7:0]             cg_cmd;
    logic [7:0]             blink_cmd;
    logic [WW:0]            wait_sum;
    logic                   row_done;

    assign s_axis_tready = !r_busy;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    // advance one step whenever the output register is free or being drained
    assign step_en       = r_busy && (!r_out_valid || m_axis_tready);

    assign cw        = lcd_seq_pkg::ucode(r_pc);
    assign goto_cmd  = 8'h80 + {2'b00, r_column} + {r_row, 6'b000000};
    assign cg_cmd    = {2'b01, r_glyph_code, 3'b000};
    assign blink_cmd = r_cursor_blink ? 8'h0F : 8'h0C;
    assign wait_sum  = {1'b0, r_nibble_wait} + {1'b0, lcd_seq_pkg::extra_wait(cw.extra)};
    assign row_done  = (r_row_cnt == RW'(lcd_seq_pkg::GLYPH_ROW_COUNT - 1));

    // datapath: pick the nibble and select level for the current step
    always_comb begin
        n_out_nib = cw.nib_const;
        case (cw.nib_src)
            lcd_seq_pkg::NS_BYTE_HI:  n_out_nib = r_byte[7:4];
            lcd_seq_pkg::NS_BYTE_LO:  n_out_nib = r_byte[3:0];
            lcd_seq_pkg::NS_GOTO_HI:  n_out_nib = goto_cmd[7:4];
            lcd_seq_pkg::NS_GOTO_LO:  n_out_nib = goto_cmd[3:0];
            lcd_seq_pkg::NS_CG_HI:    n_out_nib = cg_cmd[7:4];
            lcd_seq_pkg::NS_CG_LO:    n_out_nib = cg_cmd[3:0];
            lcd_seq_pkg::NS_ROW_HI:   n_out_nib = r_rows[7:4];
            lcd_seq_pkg::NS_ROW_LO:   n_out_nib = r_rows[3:0];
            lcd_seq_pkg::NS_BLINK_LO: n_out_nib = blink_cmd[3:0];
            default:                  n_out_nib = cw.nib_const;
        endcase

        case (cw.sel_src)
            lcd_seq_pkg::SS_ONE:     n_out_sel = 1'b1;
            lcd_seq_pkg::SS_IS_DATA: n_out_sel = r_is_data;
            default:                 n_out_sel = 1'b0;
        endcase

        // saturate the wait at the field's full scale
        n_out_wait = wait_sum[WW] ? {WW{1'b1}} : wait_sum[WW-1:0];
    end

    // sequencer: step counter, row loop and end of run
    always_comb begin
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_row_cnt   = r_row_cnt;
        n_rows      = r_rows;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_last  = 1'b0;

        if (s_acc) begin
            n_busy    = 1'b1;
            n_pc      = lcd_seq_pkg::entry_pc(s_axis_tuser[1:0]);
            n_row_cnt = '0;
            n_rows    = s_axis_tdata[81:18];
        end else if (step_en) begin
            n_out_valid = 1'b1;
            case (cw.flow)
                lcd_seq_pkg::FL_NEXT: begin
                    n_pc = r_pc + 1'b1;
                end
                lcd_seq_pkg::FL_ROW_LOOP: begin
                    if (row_done) begin
                        n_busy     = 1'b0;
                        n_out_last = 1'b1;
                    end else begin
                        // jump back for the next row byte
                        n_pc      = lcd_seq_pkg::PC_ROW_TOP;
                        n_row_cnt = r_row_cnt + 1'b1;
                        n_rows    = {8'h00, r_rows[63:8]};
                    end
                end
                default: begin
                    n_busy     = 1'b0;
                    n_out_last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_pc           <= '0;
            r_row_cnt      <= '0;
            r_cursor_blink <= 1'b0;
            r_nibble_wait  <= lcd_seq_pkg::NIBBLE_WAIT_RESET;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_pc        <= n_pc;
            r_row_cnt   <= n_row_cnt;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    lcd_seq_pkg::CFG_CURSOR_BLINK: r_cursor_blink <= i_cfg_data[0];
                    lcd_seq_pkg::CFG_NIBBLE_WAIT:  r_nibble_wait  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers: capture the request, load the output on each step
    always_ff @(posedge i_clk) begin
        r_rows <= n_rows;
        if (s_acc) begin
            r_byte       <= s_axis_tdata[7:0];
            r_column     <= s_axis_tdata[13:8];
            r_row        <= s_axis_tdata[14];
            r_glyph_code <= s_axis_tdata[17:15];
            r_is_data    <= s_axis_tuser[2];
        end
        if (step_en) begin
            r_out_sel  <= n_out_sel;
            r_out_nib  <= n_out_nib;
            r_out_wait <= n_out_wait;
            r_out_last <= n_out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'h0, r_out_wait, r_out_nib};
    assign m_axis_tuser  = r_out_sel;
    assign m_axis_tlast  = r_out_last;

endmodule
